// ----- rtl/core/mlru_pkg.sv -----
// ----------------------------------------------------------------------------
// mlru_pkg
// Shared constants and types for the matrix LRU page replacement block.
// ----------------------------------------------------------------------------
package mlru_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int CFG_W         = 4;
  localparam int FAULT_W       = 16;
  localparam int FRAME_IDX_W   = 3;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

// ----- rtl/core/mlru_if.sv -----
// ----------------------------------------------------------------------------
// mlru channel interfaces
// Valid/ready channels for page requests, results and the configuration write.
// ----------------------------------------------------------------------------
interface mlru_req_if #(
  parameter int PAGE_BITS = mlru_pkg::PAGE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface mlru_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 page_fault;
  logic [mlru_pkg::FRAME_IDX_W-1:0]     frame_index;
  logic [mlru_pkg::FAULT_W-1:0]         fault_total;

  modport source (output valid, output page_fault, output frame_index,
                  output fault_total, input ready);
  modport sink   (input valid, input page_fault, input frame_index,
                  input fault_total, output ready);
endinterface

interface mlru_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mlru_pkg::CFG_W-1:0]   active_frames;

  modport source (output valid, output active_frames, input ready);
  modport sink   (input valid, input active_frames, output ready);
endinterface

// ----- rtl/core/matrix_lru_page_replacement_top.sv -----
// ----------------------------------------------------------------------------
// matrix_lru_page_replacement_top
// Matrix LRU page replacement: one page request in, one result out, with
// a frame table and an N-by-N use matrix scanned by one shared compare and
// row-count unit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_req    in   valid/ready        page_number
//  out_rsp   out  valid/ready        page_fault, frame_index, fault_total
//  cfg_wr    in   valid/ready        active_frames (always ready)
//
//  After acceptance, each request scans its n active frames (n = active frame
//  count) one frame per cycle through the shared page compare and row-count
//  unit, then takes one update step.
//  The block takes a new request only when the sequencer is idle, so a new
//  request is not accepted until the last one has finished its update; a
//  pending result sits in the output register, and the update step waits
//  while it is still unclaimed. Reset clears the valid marks, matrix and
//  fault count at once.
// ----------------------------------------------------------------------------
module matrix_lru_page_replacement_top #(
  parameter int MAX_FRAMES = mlru_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = mlru_pkg::PAGE_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  mlru_req_if.sink   in_req,
  mlru_rsp_if.source out_rsp,
  mlru_cfg_if.sink   cfg_wr
);
  import mlru_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]      cfg_active_r;
  logic [CNT_W-1:0]      n_r;
  logic [CNT_W-1:0]      n_now;
  logic [CNT_W-1:0]      scan_r;
  logic [PAGE_BITS-1:0]  page_r;
  logic                  hit_r;
  logic [IDX_W-1:0]      hit_idx_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [CNT_W-1:0]      best_sum_r;

  logic                  valid_r [MAX_FRAMES];
  logic [PAGE_BITS-1:0]  fpage_r [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] row_r   [MAX_FRAMES];
  logic [FAULT_W-1:0]    fault_cnt_r;

  logic                  out_valid_r;
  logic                  out_fault_r;
  logic [FRAME_IDX_W-1:0] out_idx_r;
  logic [FAULT_W-1:0]    out_total_r;

  logic                  accept;
  logic                  scan_en;
  logic                  upd_go;
  logic                  scan_last;
  logic                  out_free;

  logic [IDX_W-1:0]      cur_idx;
  logic                  cur_hit;
  logic [CNT_W-1:0]      cur_sum;
  logic [MAX_FRAMES-1:0] act_mask;
  logic [IDX_W-1:0]      victim;
  logic [FAULT_W-1:0]    fault_cnt_nxt;

  // Clamp the configured count into 1..MAX_FRAMES.
  always_comb begin
    if (cfg_active_r == '0) begin
      n_now = CNT_W'(1);
    end else if (32'(cfg_active_r) > 32'(MAX_FRAMES)) begin
      n_now = CNT_W'(MAX_FRAMES);
    end else begin
      n_now = CNT_W'(cfg_active_r);
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_FRAMES; j++) begin
      act_mask[j] = (32'(j) < 32'(n_r));
    end
  end

  // Shared unit: page compare and masked row count for one frame per cycle.
  assign cur_idx = scan_r[IDX_W-1:0];
  assign cur_hit = valid_r[cur_idx] && (fpage_r[cur_idx] == page_r);

  always_comb begin
    logic [MAX_FRAMES-1:0] bits;
    bits    = row_r[cur_idx] & act_mask;
    cur_sum = '0;
    for (int j = 0; j < MAX_FRAMES; j++) begin
      cur_sum = cur_sum + CNT_W'(bits[j]);
    end
  end

  assign scan_last = (scan_r == n_r - CNT_W'(1));
  assign out_free  = !out_valid_r || out_rsp.ready;
  assign victim    = hit_r ? hit_idx_r : best_idx_r;
  assign fault_cnt_nxt = (fault_cnt_r == '1) ? fault_cnt_r : fault_cnt_r + FAULT_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_req.ready = 1'b0;
    scan_en      = 1'b0;
    upd_go       = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_req.ready = 1'b1;
      ST_SCAN:   scan_en      = 1'b1;
      ST_UPDATE: upd_go       = out_free;
      default: ;
    endcase
  end

  assign accept = in_req.valid && in_req.ready;
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_active_r <= ACTIVE_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr.valid) begin
        cfg_active_r <= cfg_wr.active_frames;
      end
    end
  end

  // Scan bookkeeping.
  always_ff @(posedge clk) begin
    if (accept) begin
      page_r <= in_req.page_number;
      n_r    <= n_now;
      scan_r <= '0;
      hit_r  <= 1'b0;
    end else if (scan_en) begin
      scan_r <= scan_r + CNT_W'(1);
      if (cur_hit && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= cur_idx;
      end
      // Strict less-than keeps the lowest index on ties.
      if (scan_r == '0 || cur_sum < best_sum_r) begin
        best_sum_r <= cur_sum;
        best_idx_r <= cur_idx;
      end
    end
  end

  // Frame table, matrix and fault count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        valid_r[i] <= 1'b0;
        row_r[i]   <= '0;
      end
      fault_cnt_r <= '0;
    end else if (upd_go) begin
      if (!hit_r) begin
        valid_r[victim] <= 1'b1;
        fpage_r[victim] <= page_r;
        fault_cnt_r     <= fault_cnt_nxt;
      end
      // Touch: set the victim's row over active columns, then clear its column.
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (act_mask[i]) begin
          if (IDX_W'(i) == victim) begin
            row_r[i] <= (row_r[i] | act_mask) & ~(MAX_FRAMES'(1) << victim);
          end else begin
            row_r[i] <= row_r[i] & ~(MAX_FRAMES'(1) << victim);
          end
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_fault_r <= !hit_r;
      out_idx_r   <= FRAME_IDX_W'(victim);
      out_total_r <= hit_r ? fault_cnt_r : fault_cnt_nxt;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.page_fault  = out_fault_r;
  assign out_rsp.frame_index = out_idx_r;
  assign out_rsp.fault_total = out_total_r;

endmodule
